/* hdl/caller_id_line_parser_assert.svh */
`ifndef CALLER_ID_LINE_PARSER_ASSERT_SVH
`define CALLER_ID_LINE_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/clp_pkg.sv */
package clp_pkg;

	localparam int FIELD_MAX = 19;
	localparam int LINE_MAX  = 100;

	localparam int LINE_W = 7;
	localparam int LEN_W  = $clog2(FIELD_MAX + 1);
	localparam int IDX_W  = $clog2(FIELD_MAX);

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_NUL = 8'd0;

	localparam logic [LINE_W-1:0] FIELD_COL = LINE_W'(7);
	localparam logic [LINE_W-1:0] TAG_COLS  = LINE_W'(4);
	localparam logic [LEN_W-1:0]  MIN_STAMP = LEN_W'(4);

	localparam logic [31:0] TAG_DATE = 32'h4441_5445;
	localparam logic [31:0] TAG_TIME = 32'h5449_4D45;
	localparam logic [31:0] TAG_NMBR = 32'h4E4D_4252;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cr;
		logic nmbr_end;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

/* hdl/clp_ctrl.sv */
module clp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  clp_pkg::stat_t stat,
	output logic           in_stall,
	output clp_pkg::cmd_t  cmd
);
	import clp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				// number line end: hold the line and play it out
				if (in_valid && stat.cr && stat.nmbr_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				in_stall = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/clp_dpath.sv */
module clp_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     byte_in,
	input  logic           out_stall,
	input  clp_pkg::cmd_t  cmd,
	output clp_pkg::stat_t stat,
	output logic           out_valid,
	output logic [15:0]    day_text,
	output logic [15:0]    month_text,
	output logic [15:0]    hour_text,
	output logic [15:0]    minute_text,
	output logic [7:0]     number_char,
	output logic           number_empty,
	output logic           last
);
	import clp_pkg::*;

	logic [LINE_W-1:0] line_count_q;
	logic [31:0]       tag_q;
	logic [LEN_W-1:0]  len_q;
	logic              ended_q;
	logic [LEN_W-1:0]  idx_q;
	logic [15:0]       day_q;
	logic [15:0]       month_q;
	logic [15:0]       hour_q;
	logic [15:0]       minute_q;
	logic              out_valid_q;
	logic [7:0]        store_q [FIELD_MAX];

	logic is_cr;
	logic is_lf;
	logic is_char;
	logic in_line;
	logic in_field;
	logic store_we;
	logic long_line;
	logic stamp_ok;
	logic len_zero;

	assign is_cr     = (byte_in == CH_CR);
	assign is_lf     = (byte_in == CH_LF);
	assign is_char   = !is_cr && !is_lf;
	assign in_line   = (line_count_q < LINE_W'(LINE_MAX));
	assign in_field  = (line_count_q >= FIELD_COL) && !ended_q;
	assign store_we  = cmd.take && is_char && in_line && in_field && (byte_in != CH_NUL)
		&& (len_q < LEN_W'(FIELD_MAX));
	assign long_line = (line_count_q > FIELD_COL);
	assign stamp_ok  = (len_q >= MIN_STAMP);
	assign len_zero  = (len_q == '0);

	always_comb begin
		stat.cr        = is_cr;
		stat.nmbr_end  = long_line && (tag_q == TAG_NMBR);
		stat.emit_last = len_zero || (LEN_W'(idx_q + 1'b1) == len_q);
		stat.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			tag_q        <= '0;
			len_q        <= '0;
			ended_q      <= 1'b0;
			idx_q        <= '0;
			day_q        <= '0;
			month_q      <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take && is_char && in_line) begin
				if (line_count_q < TAG_COLS) begin
					unique case (line_count_q[1:0])
						2'd0: tag_q[31:24] <= byte_in;
						2'd1: tag_q[23:16] <= byte_in;
						2'd2: tag_q[15:8]  <= byte_in;
						2'd3: tag_q[7:0]   <= byte_in;
						default: tag_q <= tag_q;
					endcase
				end else if (in_field) begin
					if (byte_in == CH_NUL) begin
						ended_q <= 1'b1;
					end else if (store_we) begin
						len_q <= LEN_W'(len_q + 1'b1);
					end
				end
				line_count_q <= LINE_W'(line_count_q + 1'b1);
			end else if (cmd.take && is_cr) begin
				if (stat.nmbr_end) begin
					idx_q <= '0;
				end else begin
					if (long_line && stamp_ok && (tag_q == TAG_DATE)) begin
						day_q   <= {store_q[0], store_q[1]};
						month_q <= {store_q[2], store_q[3]};
					end
					if (long_line && stamp_ok && (tag_q == TAG_TIME)) begin
						hour_q   <= {store_q[0], store_q[1]};
						minute_q <= {store_q[2], store_q[3]};
					end
					line_count_q <= '0;
					tag_q        <= '0;
					len_q        <= '0;
					ended_q      <= 1'b0;
				end
			end

			if (cmd.emit) begin
				idx_q <= LEN_W'(idx_q + 1'b1);
				if (stat.emit_last) begin
					line_count_q <= '0;
					tag_q        <= '0;
					len_q        <= '0;
					ended_q      <= 1'b0;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[len_q[IDX_W-1:0]] <= byte_in;
		end
		if (cmd.emit) begin
			day_text     <= day_q;
			month_text   <= month_q;
			hour_text    <= hour_q;
			minute_text  <= minute_q;
			number_char  <= len_zero ? CH_NUL : store_q[idx_q[IDX_W-1:0]];
			number_empty <= len_zero;
			last         <= stat.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/caller_id_line_parser.sv */
// a byte is taken when valid and not stalled; most bytes and line ends produce no result
// a number line end moves the controller to its emit state and each result is registered;
// the field sequencer then gives one result per cycle while the output does not stall, and
// the input stalls until the last one is out; throughput is one byte per cycle otherwise
// reset (arst_n low, asynchronous) clears line state, stored date and time text and the
// sequencer; the field store is not cleared and is only read below the field length
module caller_id_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] day_text,
	output logic [15:0] month_text,
	output logic [15:0] hour_text,
	output logic [15:0] minute_text,
	output logic [7:0]  number_char,
	output logic        number_empty,
	output logic        last
);
	import clp_pkg::*;

	`include "caller_id_line_parser_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	clp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	clp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_in      (byte_in),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.day_text     (day_text),
		.month_text   (month_text),
		.hour_text    (hour_text),
		.minute_text  (minute_text),
		.number_char  (number_char),
		.number_empty (number_empty),
		.last         (last)
	);

	`CLP_ASSERT_IMPLY(a_emit_no_overwrite, clk, arst_n, cmd.emit, !(out_valid && out_stall), "result overwritten while waiting")
	`CLP_ASSERT_IMPLY(a_take_not_emit, clk, arst_n, cmd.take, !cmd.emit, "request taken during number emission")
	`CLP_ASSERT_NEXT(a_last_frees_input, clk, arst_n, cmd.emit && stat.emit_last, !in_stall, "input still stalled after last character")
	`CLP_ASSERT_NEXT(a_nmbr_stalls, clk, arst_n, in_valid && !in_stall && stat.cr && stat.nmbr_end, in_stall, "number line end did not start emission")

endmodule

/* bench/caller_scoreboard_pkg.sv */
`timescale 1ns / 100ps

package caller_scoreboard_pkg;

	import clp_pkg::*;

	typedef struct packed {
		logic [15:0] day;
		logic [15:0] month;
		logic [15:0] hour;
		logic [15:0] minute;
		logic [7:0]  ch;
		logic        empty;
		logic        last;
	} caller_rec_t;

	class caller_scoreboard;

		// shadow of the parser state
		int          line_len;
		logic [31:0] tag;
		logic [7:0]  field [FIELD_MAX];
		int          field_len;
		bit          field_done;
		logic [15:0] day;
		logic [15:0] month;
		logic [15:0] hour;
		logic [15:0] minute;

		caller_rec_t pending_q[$];
		int          produced;
		int          errors;

		function new();
			produced = 0;
			errors = 0;
			day = '0;
			month = '0;
			hour = '0;
			minute = '0;
			clear_line();
		endfunction

		function void clear_line();
			line_len = 0;
			tag = '0;
			field_len = 0;
			field_done = 1'b0;
		endfunction

		function void push_rec(logic [7:0] ch, logic empty, logic last);
			caller_rec_t rec;
			rec.day = day;
			rec.month = month;
			rec.hour = hour;
			rec.minute = minute;
			rec.ch = ch;
			rec.empty = empty;
			rec.last = last;
			pending_q.push_back(rec);
			produced++;
		endfunction

		// one accepted request byte
		function void note_request(logic [7:0] b);
			int i;
			if (b == CH_LF)
				return;
			if (b != CH_CR) begin
				if (line_len >= LINE_MAX)
					return;
				if (line_len < 4) begin
					tag = tag | ({24'h0, b} << (8 * (3 - line_len)));
				end else if (line_len >= int'(FIELD_COL) && !field_done) begin
					if (b == CH_NUL)
						field_done = 1'b1;
					else if (field_len < FIELD_MAX) begin
						field[field_len] = b;
						field_len++;
					end
				end
				line_len++;
				return;
			end
			// carriage return: act on the finished line
			if (line_len > int'(FIELD_COL)) begin
				if (tag == TAG_DATE) begin
					if (field_len >= int'(MIN_STAMP)) begin
						day = {field[0], field[1]};
						month = {field[2], field[3]};
					end
				end else if (tag == TAG_TIME) begin
					if (field_len >= int'(MIN_STAMP)) begin
						hour = {field[0], field[1]};
						minute = {field[2], field[3]};
					end
				end else if (tag == TAG_NMBR) begin
					if (field_len == 0)
						push_rec(CH_NUL, 1'b1, 1'b1);
					else
						for (i = 0; i < field_len; i++)
							push_rec(field[i], 1'b0, (i + 1 == field_len));
				end
			end
			clear_line();
		endfunction

		function void check_result(caller_rec_t got);
			caller_rec_t want;
			if (pending_q.size() == 0) begin
				$error("result with nothing pending: char %h last %b", got.ch, got.last);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.day !== want.day) begin
				$error("day_text: expected %h, got %h", want.day, got.day);
				errors++;
			end
			if (got.month !== want.month) begin
				$error("month_text: expected %h, got %h", want.month, got.month);
				errors++;
			end
			if (got.hour !== want.hour) begin
				$error("hour_text: expected %h, got %h", want.hour, got.hour);
				errors++;
			end
			if (got.minute !== want.minute) begin
				$error("minute_text: expected %h, got %h", want.minute, got.minute);
				errors++;
			end
			if (got.ch !== want.ch) begin
				$error("number_char: expected %h, got %h", want.ch, got.ch);
				errors++;
			end
			if (got.empty !== want.empty) begin
				$error("number_empty: expected %b, got %b", want.empty, got.empty);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %b, got %b", want.last, got.last);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_q.size();
		endfunction

	endclass

endpackage

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	import clp_pkg::*;
	import caller_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 30;
	localparam int RANDOM_UNTIL = 150;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] day_text;
	logic [15:0] month_text;
	logic [15:0] hour_text;
	logic [15:0] minute_text;
	logic [7:0]  number_char;
	logic        number_empty;
	logic        last;

	caller_scoreboard sb;
	logic [7:0] tx_bytes[$];
	int items_sent;
	int cycle_count;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	bit hold_done;

	caller_id_line_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day_text(day_text),
		.month_text(month_text),
		.hour_text(hour_text),
		.minute_text(minute_text),
		.number_char(number_char),
		.number_empty(number_empty),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		caller_rec_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.day = day_text;
			got.month = month_text;
			got.hour = hour_text;
			got.minute = minute_text;
			got.ch = number_char;
			got.empty = number_empty;
			got.last = last;
			sb.check_result(got);
		end
	end

	// receiver: random stall bursts and one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	function automatic logic [7:0] rand_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range(48, 57));
	endfunction

	task automatic add_byte(logic [7:0] b);
		tx_bytes.push_back(b);
	endtask

	task automatic add_str(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic send_byte(logic [7:0] b);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(b);
		items_sent++;
	endtask

	task automatic send_all();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// sender pause until every pending result is out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed tagged lines with random content, some noise
	task automatic add_random_line();
		int kind;
		int flen;
		int cols;
		int r;
		int i;
		logic [31:0] tag;
		kind = $urandom_range(0, 9);
		if (kind == 8) begin
			flen = $urandom_range(0, 12);
			for (i = 0; i < flen; i++)
				add_byte(8'($urandom_range(0, 255)));
			add_byte(CH_CR);
			return;
		end
		case (kind)
			0, 1: tag = TAG_DATE;
			2, 3: tag = TAG_TIME;
			default: tag = TAG_NMBR;
		endcase
		if (kind == 9) begin
			// cut short before the field starts
			cols = $urandom_range(0, 7);
			for (i = 0; i < cols; i++)
				add_byte((i < 4) ? tag[31 - 8 * i -: 8] : rand_char());
			add_byte(CH_CR);
			return;
		end
		if ($urandom_range(0, 9) == 0)
			tag[8 * $urandom_range(0, 3) +: 8] = rand_char();
		for (i = 0; i < 4; i++)
			add_byte(tag[31 - 8 * i -: 8]);
		for (i = 0; i < 3; i++)
			add_byte(rand_char());
		r = $urandom_range(0, 19);
		if (r == 0)
			flen = $urandom_range(95, 125);
		else if (r < 4)
			flen = $urandom_range(9, 24);
		else
			flen = $urandom_range(0, 8);
		for (i = 0; i < flen; i++) begin
			r = $urandom_range(0, 29);
			if (r == 0)
				add_byte(CH_NUL);
			else if (r == 1)
				add_byte(CH_LF);
			else if (tag != TAG_NMBR && r < 25)
				add_byte(rand_digit());
			else
				add_byte(rand_char());
		end
		add_byte(CH_CR);
	endtask

	initial begin
		int i;
		sb = new();
		items_sent = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		hold_done = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		byte_in <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines
		add_str("NMBR   5551212");
		add_byte(CH_CR);
		add_byte(CH_LF);
		add_str("DATE   0412");
		add_byte(CH_CR);
		add_str("TI\nME   2359");
		add_byte(CH_CR);
		add_str("NMBR   ");
		add_byte(CH_NUL);
		add_byte(CH_CR);
		add_str("DATE   12");
		add_byte(CH_CR);
		add_str("NMBR   ");
		add_byte(CH_CR);
		add_str("NMBR   12");
		add_byte(CH_NUL);
		add_str("34");
		add_byte(CH_CR);
		add_str("NMBR   ABCDEFGHIJKLMNOPQRST");
		add_byte(CH_CR);
		send_all();
		wait_drain();

		// receiver holds off while number lines keep coming
		tx_idle = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 2; i++) begin
			add_str("NMBR   ");
			repeat ($urandom_range(1, 19)) add_byte(rand_digit());
			add_byte(CH_CR);
		end
		send_all();
		wait_drain();

		// random lines, idling switched on and off per line
		while (items_sent < RANDOM_UNTIL) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			add_random_line();
			send_all();
		end
		wait_drain();

		// closing stretch without idling
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (i = 0; i < 2; i++) begin
			add_random_line();
			send_all();
		end
		wait_drain();

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/clp_pkg.sv
hdl/clp_ctrl.sv
hdl/clp_dpath.sv
hdl/caller_id_line_parser.sv
bench/caller_scoreboard_pkg.sv
bench/testbench.sv
